### rtl/delimiter_stream_splitter_macros.svh
// assertion macros for the delimiter stream splitter
`ifndef DELIMITER_STREAM_SPLITTER_MACROS_SVH
`define DELIMITER_STREAM_SPLITTER_MACROS_SVH

`ifndef ASSERT_OFF

`define DSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define DSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define DSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define DSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/dss_pkg.sv
// shared types and constants of the delimiter stream splitter
package dss_pkg;

    localparam int LEN_W    = 4;
    localparam int LEN_EXT_W = 5;
    localparam int DBYTES_W = 64;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DELIM_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_EMPTY  = 2'd2;

    localparam logic [LEN_W-1:0]    DELIM_LEN_RST   = 4'd1;
    localparam logic [DBYTES_W-1:0] DELIM_BYTES_RST = 64'd44;

    localparam logic ITEM_CHAR = 1'b0;
    localparam logic ITEM_END  = 1'b1;

    typedef struct packed {
        logic shift;
        logic push;
    } cell_ctrl_t;

endpackage

### rtl/dss_if.sv
// character and result channel interfaces
interface dss_char_if #(
    parameter int CHAR_BITS = 8
);
    logic                 valid;
    logic                 ready;
    logic [CHAR_BITS-1:0] char_in;
    logic                 end_of_string;

    modport source (output valid, output char_in, output end_of_string, input ready);
    modport sink   (input valid, input char_in, input end_of_string, output ready);
endinterface

interface dss_result_if #(
    parameter int CHAR_BITS = 8
);
    logic                 valid;
    logic                 ready;
    logic                 item_kind;
    logic [CHAR_BITS-1:0] char_out;
    logic                 last_result;

    modport source (output valid, output item_kind, output char_out, output last_result,
                    input ready);
    modport sink   (input valid, input item_kind, input char_out, input last_result,
                    output ready);
endinterface

### rtl/dss_cell.sv
// one hold buffer cell: a held character, its delimiter compare and a match chain link
module dss_cell #(
    parameter int CHAR_BITS = 8,
    parameter int CNT_W     = 3,
    parameter int CELL_IDX  = 0
) (
    input  logic                 clk,
    input  dss_pkg::cell_ctrl_t  ctrl,
    input  logic [CNT_W-1:0]     keep,
    input  logic [CNT_W-1:0]     push_idx,
    input  logic [CHAR_BITS-1:0] new_char,
    input  logic [CHAR_BITS-1:0] right_char,
    input  logic [CHAR_BITS-1:0] delim_char,
    input  logic                 match_in,
    output logic [CHAR_BITS-1:0] held_char,
    output logic                 match_out
);

    logic [CHAR_BITS-1:0] char_reg;
    logic                 in_range;

    assign in_range  = CNT_W'(CELL_IDX) < keep;
    assign match_out = match_in && (!in_range || (char_reg == delim_char));
    assign held_char = char_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.push && (push_idx == CNT_W'(CELL_IDX)))
        begin
            char_reg <= new_char;
        end
        else if (ctrl.shift)
        begin
            char_reg <= right_char;
        end
    end

endmodule

### rtl/delimiter_stream_splitter.sv
// delimiter stream splitter top level: sequencer, cell row and result register
// Takes one character per cycle while the result side keeps up and no flush runs, and
// cuts the stream at a delimiter of delim_len characters (1 to DELIM_MAX), held in a
// row of DELIM_MAX-1 cells that compare in parallel. An ordinary character request
// gives at most one result. A request with end_of_string that ends no delimiter then
// releases each held character and closes the segment. After delim_len is lowered,
// the first request first releases each surplus held character. Results leave one per
// cycle through an output register while results.ready is high. The user must write
// configuration only while the block is idle; the block does not enforce it.
`include "delimiter_stream_splitter_macros.svh"

module delimiter_stream_splitter #(
    parameter int DELIM_MAX = 8,
    parameter int CHAR_BITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dss_pkg::CFG_W-1:0]       cfg_wdata,
    dss_char_if.sink                        chars,
    dss_result_if.source                    results
);

    localparam int CNT_W = (DELIM_MAX > 2) ? $clog2(DELIM_MAX) : 1;
    localparam int CELLS = (DELIM_MAX > 1) ? DELIM_MAX - 1 : 1;
    localparam int PAD_W = DELIM_MAX * CHAR_BITS;

    typedef enum logic {
        PH_MAIN,
        PH_FLUSH
    } phase_t;

    phase_t                          phase_reg;
    phase_t                          phase_next;
    logic [dss_pkg::LEN_W-1:0]       delim_len_reg;
    logic [dss_pkg::DBYTES_W-1:0]    delim_bytes_reg;
    logic                            skip_empty_reg;
    logic                            item_valid_reg;
    logic [CHAR_BITS-1:0]            item_char_reg;
    logic                            item_eos_reg;
    logic [CNT_W-1:0]                hold_count_reg;
    logic [CNT_W-1:0]                hold_count_next;
    logic                            seg_reg;
    logic                            seg_next;
    logic                            out_valid_reg;
    logic                            out_kind_reg;
    logic [CHAR_BITS-1:0]            out_char_reg;
    logic                            out_last_reg;

    logic [PAD_W+dss_pkg::DBYTES_W-1:0] dpad;
    logic [CHAR_BITS-1:0]            dchar [DELIM_MAX];
    logic [dss_pkg::LEN_EXT_W-1:0]   len_raw;
    logic [dss_pkg::LEN_EXT_W-1:0]   len_eff;
    logic [CNT_W-1:0]                keep;
    logic [CHAR_BITS-1:0]            held [CELLS];
    logic [CELLS:0]                  chain;
    logic                            match;
    logic                            slot_free;
    logic                            step_go;
    logic                            done;
    logic                            item_done;
    logic                            res_valid;
    logic                            res_kind;
    logic [CHAR_BITS-1:0]            res_char;
    logic                            res_last;
    logic                            shift_c;
    logic                            push_c;
    logic [CNT_W-1:0]                push_idx;
    dss_pkg::cell_ctrl_t             cell_ctrl;

    // delimiter characters, zero beyond the register
    assign dpad = {{PAD_W{1'b0}}, delim_bytes_reg};

    always_comb
    begin
        for (int k = 0; k < DELIM_MAX; k++)
        begin
            dchar[k] = dpad[k*CHAR_BITS +: CHAR_BITS];
        end
    end

    // effective length, clamped to 1..DELIM_MAX
    always_comb
    begin
        len_raw = {1'b0, delim_len_reg};
        if (len_raw == '0)
        begin
            len_eff = dss_pkg::LEN_EXT_W'(1);
        end
        else if (len_raw > dss_pkg::LEN_EXT_W'(DELIM_MAX))
        begin
            len_eff = dss_pkg::LEN_EXT_W'(DELIM_MAX);
        end
        else
        begin
            len_eff = len_raw;
        end
        keep = CNT_W'(len_eff - dss_pkg::LEN_EXT_W'(1));
    end

    // hold buffer, oldest character in cell 0
    assign chain[0]            = 1'b1;
    assign cell_ctrl.shift     = step_go && shift_c;
    assign cell_ctrl.push      = step_go && push_c;

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        logic [CHAR_BITS-1:0] right;

        if (i < CELLS - 1)
        begin : g_mid
            assign right = held[i+1];
        end
        else
        begin : g_end
            assign right = held[i];
        end

        dss_cell #(
            .CHAR_BITS (CHAR_BITS),
            .CNT_W     (CNT_W),
            .CELL_IDX  (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .keep       (keep),
            .push_idx   (push_idx),
            .new_char   (item_char_reg),
            .right_char (right),
            .delim_char (dchar[i]),
            .match_in   (chain[i]),
            .held_char  (held[i]),
            .match_out  (chain[i+1])
        );
    end

    assign match = (hold_count_reg == keep) && chain[CELLS] && (item_char_reg == dchar[keep]);

    assign slot_free   = !out_valid_reg || results.ready;
    assign step_go     = item_valid_reg && slot_free;
    assign item_done   = step_go && done;
    assign chars.ready = !item_valid_reg || item_done;

    // one sequencer step on the held request
    always_comb
    begin
        res_valid       = 1'b0;
        res_kind        = dss_pkg::ITEM_CHAR;
        res_char        = '0;
        res_last        = 1'b0;
        shift_c         = 1'b0;
        push_c          = 1'b0;
        push_idx        = hold_count_reg;
        hold_count_next = hold_count_reg;
        seg_next        = seg_reg;
        phase_next      = phase_reg;
        done            = 1'b0;

        if (phase_reg == PH_FLUSH)
        begin
            if (hold_count_reg != '0)
            begin
                res_valid       = 1'b1;
                res_char        = held[0];
                shift_c         = 1'b1;
                hold_count_next = hold_count_reg - CNT_W'(1);
                seg_next        = 1'b1;
            end
            else
            begin
                done       = 1'b1;
                phase_next = PH_MAIN;
                if (seg_reg)
                begin
                    res_valid = 1'b1;
                    res_kind  = dss_pkg::ITEM_END;
                    res_last  = 1'b1;
                end
                seg_next = 1'b0;
            end
        end
        else if (hold_count_reg > keep)
        begin
            // surplus after a shorter length was set
            res_valid       = 1'b1;
            res_char        = held[0];
            shift_c         = 1'b1;
            hold_count_next = hold_count_reg - CNT_W'(1);
            seg_next        = 1'b1;
        end
        else
        begin
            done = !item_eos_reg || match;
            if (item_eos_reg && !match)
            begin
                phase_next = PH_FLUSH;
            end
            if (match)
            begin
                hold_count_next = '0;
                if (!skip_empty_reg || seg_reg)
                begin
                    res_valid = 1'b1;
                    res_kind  = dss_pkg::ITEM_END;
                    res_last  = 1'b1;
                end
                seg_next = 1'b0;
            end
            else if (keep == '0)
            begin
                res_valid = 1'b1;
                res_char  = item_char_reg;
                res_last  = !item_eos_reg;
                seg_next  = 1'b1;
            end
            else if (hold_count_reg == keep)
            begin
                res_valid = 1'b1;
                res_char  = held[0];
                res_last  = !item_eos_reg;
                seg_next  = 1'b1;
                shift_c   = 1'b1;
                push_c    = 1'b1;
                push_idx  = hold_count_reg - CNT_W'(1);
            end
            else
            begin
                push_c          = 1'b1;
                hold_count_next = hold_count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_len_reg   <= dss_pkg::DELIM_LEN_RST;
            delim_bytes_reg <= dss_pkg::DELIM_BYTES_RST;
            skip_empty_reg  <= 1'b0;
            phase_reg       <= PH_MAIN;
            item_valid_reg  <= 1'b0;
            item_char_reg   <= '0;
            item_eos_reg    <= 1'b0;
            hold_count_reg  <= '0;
            seg_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_kind_reg    <= dss_pkg::ITEM_CHAR;
            out_char_reg    <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    dss_pkg::REG_DELIM_LEN:   delim_len_reg   <= cfg_wdata[dss_pkg::LEN_W-1:0];
                    dss_pkg::REG_DELIM_BYTES: delim_bytes_reg <= cfg_wdata;
                    dss_pkg::REG_SKIP_EMPTY:  skip_empty_reg  <= cfg_wdata[0];
                    default: ;
                endcase
            end

            if (chars.valid && chars.ready)
            begin
                item_valid_reg <= 1'b1;
                item_char_reg  <= chars.char_in;
                item_eos_reg   <= chars.end_of_string;
            end
            else if (item_done)
            begin
                item_valid_reg <= 1'b0;
            end

            if (step_go)
            begin
                phase_reg      <= phase_next;
                hold_count_reg <= hold_count_next;
                seg_reg        <= seg_next;
            end

            if (slot_free)
            begin
                out_valid_reg <= step_go && res_valid;
                out_kind_reg  <= res_kind;
                out_char_reg  <= res_char;
                out_last_reg  <= res_last;
            end
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.item_kind   = out_kind_reg;
    assign results.char_out    = out_char_reg;
    assign results.last_result = out_last_reg;

    `DSS_ASSERT_IMP(a_flush_has_item, clk, rst_n, phase_reg == PH_FLUSH, item_valid_reg)
    `DSS_ASSERT_NEXT(a_eos_clears, clk, rst_n, item_done && item_eos_reg, (hold_count_reg == '0) && !seg_reg)
    `DSS_ASSERT_IMP(a_done_marks_last, clk, rst_n, item_done && res_valid, res_last)
    `DSS_ASSERT_IMP(a_last_ends_item, clk, rst_n, step_go && res_valid && res_last, done)
    `DSS_ASSERT_IMP(a_end_no_char, clk, rst_n, out_valid_reg && (out_kind_reg == dss_pkg::ITEM_END), out_char_reg == '0)

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// testbench of the delimiter stream splitter: directed and random strings checked against a predictor
module testbench;

    localparam int DELIM_MAX   = 8;
    localparam int CHAR_BITS   = 8;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE      = 24;
    localparam int PHASE_ITEMS = 52;
    localparam int MAX_PRINTS  = 40;

    typedef struct packed {
        logic [CHAR_BITS-1:0] ch;
        logic                 eos;
    } char_req_t;

    typedef struct packed {
        logic                 kind;
        logic [CHAR_BITS-1:0] ch;
        logic                 last;
    } seg_item_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [dss_pkg::CFG_IDX_W-1:0] cfg_index = dss_pkg::REG_DELIM_LEN;
    logic [dss_pkg::CFG_W-1:0]     cfg_wdata = '0;

    dss_char_if   #(.CHAR_BITS(CHAR_BITS)) char_ch ();
    dss_result_if #(.CHAR_BITS(CHAR_BITS)) seg_ch ();

    delimiter_stream_splitter #(
        .DELIM_MAX(DELIM_MAX),
        .CHAR_BITS(CHAR_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .chars     (char_ch),
        .results   (seg_ch)
    );

    // predictor copy of configuration and state
    logic [dss_pkg::LEN_W-1:0]    len_reg   = dss_pkg::DELIM_LEN_RST;
    logic [dss_pkg::DBYTES_W-1:0] delim_reg = dss_pkg::DELIM_BYTES_RST;
    logic                         skip_reg  = 1'b0;
    logic [CHAR_BITS-1:0]         held_chars [DELIM_MAX] = '{default: '0};
    int                           held_count   = 0;
    bit                           segment_open = 1'b0;

    char_req_t string_q[$];
    seg_item_t seg_expect_q[$];

    int   errors         = 0;
    int   prints         = 0;
    int   quiet_cycles   = 0;
    int   phase_items    = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic req_taken      = 1'b0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int active_len();
        int l;
        l = len_reg;
        if (l < 1) l = 1;
        if (l > DELIM_MAX) l = DELIM_MAX;
        return l;
    endfunction

    function automatic logic [CHAR_BITS-1:0] delim_at(int k);
        return delim_reg[k*CHAR_BITS +: CHAR_BITS];
    endfunction

    function automatic void emit_seg(logic kind, logic [CHAR_BITS-1:0] ch);
        seg_item_t it;
        it.kind = kind;
        it.ch   = ch;
        it.last = 1'b0;
        seg_expect_q = {seg_expect_q, it};
    endfunction

    function automatic void release_oldest();
        emit_seg(dss_pkg::ITEM_CHAR, held_chars[0]);
        for (int i = 1; i < held_count; i++) held_chars[i-1] = held_chars[i];
        held_count--;
        segment_open = 1'b1;
    endfunction

    function automatic void split_char(logic [CHAR_BITS-1:0] c, logic eos);
        int keep;
        int base;
        bit hit;
        keep = active_len() - 1;
        base = seg_expect_q.size();
        hit  = 1'b0;
        // surplus after the length was lowered
        while (held_count > keep) release_oldest();
        if (held_count == keep)
        begin
            hit = (c == delim_at(keep));
            for (int k = 0; k < keep; k++)
                if (held_chars[k] != delim_at(k)) hit = 1'b0;
        end
        if (hit)
        begin
            held_count = 0;
            if (!skip_reg || segment_open) emit_seg(dss_pkg::ITEM_END, '0);
            segment_open = 1'b0;
        end
        else if (keep == 0)
        begin
            emit_seg(dss_pkg::ITEM_CHAR, c);
            segment_open = 1'b1;
        end
        else
        begin
            if (held_count == keep) release_oldest();
            held_chars[held_count] = c;
            held_count++;
        end
        if (eos)
        begin
            while (held_count > 0) release_oldest();
            if (segment_open) emit_seg(dss_pkg::ITEM_END, '0);
            segment_open = 1'b0;
        end
        if (seg_expect_q.size() > base) seg_expect_q[seg_expect_q.size()-1].last = 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        errors++;
        if (prints < MAX_PRINTS)
        begin
            prints++;
            $display("%0t mismatch %s: got %h, want %h", $time, what, got, want);
        end
    endtask

    // result check and prediction
    always @(posedge clk)
    begin : monitor
        seg_item_t want;
        if (rst_n)
        begin
            if (seg_ch.valid && seg_ch.ready)
            begin
                if (seg_expect_q.size() == 0)
                    report_mismatch("unexpected result",
                                    16'({seg_ch.item_kind, seg_ch.char_out}), '0);
                else
                begin
                    want = seg_expect_q.pop_front();
                    if (seg_ch.item_kind !== want.kind)
                        report_mismatch("item_kind", 16'(seg_ch.item_kind), 16'(want.kind));
                    if (seg_ch.char_out !== want.ch)
                        report_mismatch("char_out", 16'(seg_ch.char_out), 16'(want.ch));
                    if (seg_ch.last_result !== want.last)
                        report_mismatch("last_result", 16'(seg_ch.last_result),
                                        16'(want.last));
                end
            end
            if (char_ch.valid && char_ch.ready)
                split_char(char_ch.char_in, char_ch.end_of_string);
            req_taken <= char_ch.valid && char_ch.ready;
        end
    end

    always @(negedge clk)
    begin : driver
        char_req_t req;
        if (!rst_n)
        begin
            char_ch.valid         <= 1'b0;
            char_ch.char_in       <= '0;
            char_ch.end_of_string <= 1'b0;
            seg_ch.ready          <= 1'b0;
        end
        else
        begin
            if (!char_ch.valid || req_taken)
            begin
                if (string_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    req = string_q.pop_front();
                    char_ch.valid         <= 1'b1;
                    char_ch.char_in       <= req.ch;
                    char_ch.end_of_string <= req.eos;
                end
                else
                    char_ch.valid <= 1'b0;
            end
            seg_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((char_ch.valid && char_ch.ready) || (seg_ch.valid && seg_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [dss_pkg::CFG_IDX_W-1:0] idx, logic [dss_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == dss_pkg::REG_DELIM_LEN) len_reg = val[dss_pkg::LEN_W-1:0];
        else if (idx == dss_pkg::REG_DELIM_BYTES) delim_reg = val;
        else if (idx == dss_pkg::REG_SKIP_EMPTY) skip_reg = val[0];
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (string_q.size() != 0 || char_ch.valid || seg_expect_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_idle(int mode);
        case (mode)
            1:
            begin
                send_idle_pct  = 70;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 70;
            end
            3:
            begin
                send_idle_pct  = 19;
                recv_stall_pct = 19;
            end
            default:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    function automatic void push_req(logic [CHAR_BITS-1:0] ch, logic eos);
        char_req_t req;
        req.ch  = ch;
        req.eos = eos;
        string_q = {string_q, req};
        phase_items++;
    endfunction

    function automatic void push_text(string s, bit eos_last);
        for (int i = 0; i < s.len(); i++) push_req(s[i], eos_last && (i == s.len() - 1));
    endfunction

    function automatic logic [CHAR_BITS-1:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 8'(8'h61 + $urandom_range(0, 2));
        if (r < 65) return delim_at($urandom_range(0, active_len() - 1));
        return 8'($urandom);
    endfunction

    // mostly well-formed strings with delimiters, some partial matches and stray ends
    function automatic void gen_string(int n, bit terminate);
        int l;
        int r;
        int cut;
        l = active_len();
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 22)
            begin
                for (int k = 0; k < l; k++) push_req(delim_at(k), $urandom_range(0, 99) < 2);
            end
            else if (r < 30 && l > 1)
            begin
                cut = $urandom_range(1, l - 1);
                for (int k = 0; k < cut; k++) push_req(delim_at(k), 1'b0);
            end
            else
                push_req(pick_char(), $urandom_range(0, 99) < 3);
        end
        if (terminate) push_req(pick_char(), 1'b1);
    endfunction

    task automatic random_config(int phase);
        logic [dss_pkg::LEN_W-1:0]    l;
        logic [dss_pkg::DBYTES_W-1:0] d;
        logic [dss_pkg::CFG_W-1:0]    v;
        case (phase)
            0:       l = 4'd1;
            1:       l = 4'd8;
            2:       l = 4'd15;
            3:       l = 4'd0;
            default: l = 4'($urandom_range(1, 8));
        endcase
        d = {$urandom, $urandom};
        if (phase != 4)
            for (int k = 0; k < DELIM_MAX; k++)
                if ($urandom_range(0, 9) < 8)
                    d[k*CHAR_BITS +: CHAR_BITS] = 8'(8'h61 + $urandom_range(0, 2));
        v = {$urandom, $urandom};
        v[dss_pkg::LEN_W-1:0] = l;
        write_reg(dss_pkg::REG_DELIM_LEN, v);
        write_reg(dss_pkg::REG_DELIM_BYTES, d);
        v = {$urandom, $urandom};
        v[0] = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
        write_reg(dss_pkg::REG_SKIP_EMPTY, v);
        end_writes();
    endtask

    initial
    begin
        set_idle(0);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset delimiter, empty segments kept, extreme characters
        push_text(",a,,", 1'b0);
        push_req(8'h00, 1'b0);
        push_req(8'hFF, 1'b1);
        push_req(8'h2C, 1'b1);
        drain();

        // zero length acts as one, empty segments dropped
        write_reg(dss_pkg::REG_SKIP_EMPTY, 64'd1);
        write_reg(dss_pkg::REG_DELIM_LEN, 64'd0);
        end_writes();
        push_text(",,b,,c", 1'b1);
        drain();

        // oversized length acts as the maximum
        write_reg(dss_pkg::REG_DELIM_LEN, 64'd15);
        write_reg(dss_pkg::REG_DELIM_BYTES, 64'h4847_4645_4443_4241);
        end_writes();
        push_text("xABCDEFGHy", 1'b1);
        drain();

        // no overlapping matches, then leave a character held
        write_reg(dss_pkg::REG_DELIM_LEN, 64'd2);
        write_reg(dss_pkg::REG_DELIM_BYTES, 64'h6161);
        write_reg(dss_pkg::REG_SKIP_EMPTY, 64'd0);
        end_writes();
        push_text("aaab", 1'b0);
        drain();

        // length lowered with a character still held
        write_reg(dss_pkg::REG_DELIM_LEN, 64'd1);
        write_reg(dss_pkg::REG_DELIM_BYTES, 64'h71);
        end_writes();
        push_text("q", 1'b1);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            random_config(p);
            set_idle(p % 4);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) gen_string($urandom_range(0, 10), 1'b1);
            // unfinished string carried into the next setting
            if ($urandom_range(0, 1)) gen_string(3, 1'b0);
            drain();
        end

        if (seg_expect_q.size() != 0)
            report_mismatch("results missing", 16'(seg_expect_q.size()), '0);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
